[hdl/histogram_mode_finder_unit_defines.svh]
// assertion macros for the histogram mode finder top level
`ifndef HISTOGRAM_MODE_FINDER_UNIT_DEFINES_SVH
`define HISTOGRAM_MODE_FINDER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/hmf_pkg.sv]
`timescale 1ns / 1ps

package hmf_pkg;

    // histogram geometry
    localparam int VALUE_COUNT = 256;
    localparam int COUNT_BITS  = 16;
    localparam int ADDR_BITS   = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;

    // fixed field widths
    localparam int SAMPLE_BITS = 8;
    localparam int RESULT_BITS = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [ADDR_BITS-1:0]  CLEAR_LAST = ADDR_BITS'(VALUE_COUNT - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // controller strobes towards the datapath
    typedef struct packed {
        logic accept;
        logic update;
        logic clearing;
    } ctl_t;

    // saturate a count to the result field width
    function automatic logic [RESULT_BITS-1:0] sat_result(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        begin
            w = 32'(c);
            sat_result = (w > 32'h0000_FFFF) ? 16'hFFFF : w[RESULT_BITS-1:0];
        end
    endfunction

endpackage

[hdl/hmf_ram.sv]
`timescale 1ns / 1ps

module hmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         addr,
    input  logic [WIDTH-1:0]                 wdata,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/hmf_ctrl.sv]
`timescale 1ns / 1ps

module hmf_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     item_last,
    input  logic                     out_free,
    output logic                     s_tready,
    output hmf_pkg::ctl_t            ctl,
    output logic [hmf_pkg::ADDR_BITS-1:0] clear_addr
);
    import hmf_pkg::*;

    state_t                state_reg, state_next;
    logic [ADDR_BITS-1:0]  clear_idx_reg, clear_idx_next;
    logic                  proceed;

    // a last transaction waits until the output register can take the result
    assign proceed = !item_last || out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_idx_reg == CLEAR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (proceed)
                begin
                    state_next = item_last ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready     = 1'b0;
        ctl.accept   = 1'b0;
        ctl.update   = 1'b0;
        ctl.clearing = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clearing = 1'b1;
            end
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                ctl.accept = s_tvalid;
            end
            ST_UPDATE:
            begin
                ctl.update = proceed;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // sweep pointer, back to zero once a sweep is done
    always_comb
    begin
        clear_idx_next = clear_idx_reg;
        if (ctl.clearing)
        begin
            clear_idx_next = (clear_idx_reg == CLEAR_LAST) ? '0 : clear_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
        end
    end

    assign clear_addr = clear_idx_reg;

endmodule

[hdl/hmf_best.sv]
`timescale 1ns / 1ps

module hmf_best (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hmf_pkg::ctl_t                     ctl,
    input  logic [hmf_pkg::SAMPLE_BITS-1:0]   sample_value,
    input  logic                              last_item,
    input  logic [hmf_pkg::COUNT_BITS-1:0]    rd_count,
    output logic                              wr_en,
    output logic [hmf_pkg::ADDR_BITS-1:0]     wr_addr,
    output logic [hmf_pkg::COUNT_BITS-1:0]    wr_count,
    output logic                              item_last,
    output logic [hmf_pkg::SAMPLE_BITS-1:0]   res_value,
    output logic [hmf_pkg::COUNT_BITS-1:0]    res_count
);
    import hmf_pkg::*;

    logic [SAMPLE_BITS-1:0] value_reg;
    logic                   last_reg;
    logic                   in_range;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   better;
    logic [SAMPLE_BITS-1:0] best_value_reg, best_value_next;
    logic [COUNT_BITS-1:0]  best_count_reg, best_count_next;

    // item register, loaded on the input transaction
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            value_reg <= sample_value;
            last_reg  <= last_item;
        end
    end

    assign in_range  = 32'(value_reg) < VALUE_COUNT;
    assign count_inc = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;

    // write back the raised count
    assign wr_en    = ctl.update && in_range;
    assign wr_addr  = ADDR_BITS'(value_reg);
    assign wr_count = count_inc;

    // strict greater, or equal with a smaller value
    assign better = in_range &&
                    ((count_inc > best_count_reg) ||
                     ((count_inc == best_count_reg) && (value_reg < best_value_reg)));

    assign res_value = better ? value_reg : best_value_reg;
    assign res_count = better ? count_inc : best_count_reg;

    // running best, cleared when the set ends
    always_comb
    begin
        best_value_next = best_value_reg;
        best_count_next = best_count_reg;
        if (ctl.update)
        begin
            if (last_reg)
            begin
                best_value_next = '0;
                best_count_next = '0;
            end
            else
            begin
                best_value_next = res_value;
                best_count_next = res_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_value_reg <= '0;
            best_count_reg <= '0;
        end
        else
        begin
            best_value_reg <= best_value_next;
            best_count_reg <= best_count_next;
        end
    end

    assign item_last = last_reg;

endmodule

[hdl/histogram_mode_finder_unit.sv]
`timescale 1ns / 1ps

// Histogram mode finder: counts each incoming 8-bit value in a 256-entry
// histogram of 16-bit saturating counts held in one single-port memory, and
// on the transaction flagged by s_tlast returns the most frequent value
// (smallest on ties) and its count. For each input transaction the histogram
// entry is read on acceptance; then, in ST_UPDATE, the raised count is
// written back and the running best updated, as the single memory port
// allows one access per cycle. After reset and after every last transaction
// the block sweeps all 256 entries back to zero, one entry per cycle, with
// s_tready low. Results sit in an output register, so a pending result
// does not hold up the next set; only a second last transaction waits for it.
module histogram_mode_finder_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] sample_value
    input  logic         s_tlast,   // last_item
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata    // [7:0] mode_value, [23:8] mode_count
);
    import hmf_pkg::*;

    `include "histogram_mode_finder_unit_defines.svh"

    ctl_t                   ctl;
    logic [ADDR_BITS-1:0]   clear_addr;
    logic                   item_last;
    logic                   out_free;
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0]  wr_count;
    logic [COUNT_BITS-1:0]  rd_count;
    logic [SAMPLE_BITS-1:0] res_value;
    logic [COUNT_BITS-1:0]  res_count;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_addr;
    logic [COUNT_BITS-1:0]  ram_wdata;
    logic                   m_valid_reg, m_valid_next;
    logic [23:0]            m_data_reg;
    logic                   result_load;

    hmf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .item_last  (item_last),
        .out_free   (out_free),
        .s_tready   (s_tready),
        .ctl        (ctl),
        .clear_addr (clear_addr)
    );

    hmf_best u_best (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sample_value (s_tdata[SAMPLE_BITS-1:0]),
        .last_item    (s_tlast),
        .rd_count     (rd_count),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_count     (wr_count),
        .item_last    (item_last),
        .res_value    (res_value),
        .res_count    (res_count)
    );

    // memory port: sweep, read on accept, or write back
    always_comb
    begin
        ram_we    = wr_en;
        ram_addr  = wr_addr;
        ram_wdata = wr_count;
        if (ctl.clearing)
        begin
            ram_we    = 1'b1;
            ram_addr  = clear_addr;
            ram_wdata = '0;
        end
        else if (ctl.accept)
        begin
            ram_addr = ADDR_BITS'(s_tdata[SAMPLE_BITS-1:0]);
        end
    end

    hmf_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (VALUE_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ctl.accept),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd_count)
    );

    // output register
    assign out_free    = !m_valid_reg || m_tready;
    assign result_load = ctl.update && item_last;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (result_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            m_data_reg <= {sat_result(res_count), res_value};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    `HMF_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "input accepted while an item is in flight")
    `HMF_ASSERT_IMPLY(a_sweep_writes_zero, clk, rst_n, ctl.clearing, ram_we && (ram_wdata == '0) && !s_tready, "histogram sweep not writing zero")
    `HMF_ASSERT_IMPLY(a_empty_mode_is_zero, clk, rst_n, m_tvalid && (m_tdata[23:8] == 16'h0000), m_tdata[7:0] == 8'h00, "zero count with non-zero mode value")
    `HMF_ASSERT_IMPLY(a_no_result_overrun, clk, rst_n, result_load, out_free, "result loaded over a pending result")

endmodule

[tb/sv/histogram_mode_finder_unit_test.sv]
`timescale 1ns / 1ps

module histogram_mode_finder_unit_test;

    import hmf_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int REPORT_LIMIT  = 10;
    localparam int DIRECTED_ROWS = 20;

    // one mode result as it leaves the block
    typedef struct packed {
        logic [7:0]  value;
        logic [15:0] count;
    } mode_result_t;

    // one row of the directed table, with an optional hand-written result
    typedef struct packed {
        logic [7:0]  sample;
        logic        last;
        logic        typed;
        logic [7:0]  exp_value;
        logic [15:0] exp_count;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] sample_value
    logic        s_tlast;   // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // [7:0] mode_value, [23:8] mode_count

    // histogram mirror and running mode of the current set
    logic [COUNT_BITS-1:0] hist_mirror [VALUE_COUNT];
    logic [7:0]            lead_value;
    logic [COUNT_BITS-1:0] lead_count;
    mode_result_t          pending_modes [$];

    int  fail_count   = 0;
    int  quiet_cycles = 0;
    bit  idle_on;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'd0,   1'b1, 1'b1, 8'd0,   16'd1},
        '{8'd255, 1'b1, 1'b1, 8'd255, 16'd1},
        '{8'd7,   1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd7,   1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd9,   1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd9,   1'b1, 1'b1, 8'd7,   16'd2},
        '{8'd9,   1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd7,   1'b1, 1'b1, 8'd7,   16'd1},
        '{8'd128, 1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd1,   1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd128, 1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd64,  1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd64,  1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd64,  1'b1, 1'b0, 8'd0,   16'd0},
        '{8'd170, 1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd85,  1'b1, 1'b0, 8'd0,   16'd0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd255, 1'b0, 1'b0, 8'd0,   16'd0},
        '{8'd0,   1'b1, 1'b0, 8'd0,   16'd0},
        '{8'd3,   1'b1, 1'b0, 8'd0,   16'd0}
    };

    histogram_mode_finder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // empty the histogram mirror and the running mode
    function automatic void clear_mirror();
        for (int i = 0; i < VALUE_COUNT; i++)
        begin
            hist_mirror[i] = '0;
        end
        lead_value = '0;
        lead_count = '0;
    endfunction

    // count one accepted sample and queue the mode when it closes the set
    function automatic void tally_sample(input logic [7:0] sample, input logic last,
                                         input logic typed, input mode_result_t typed_mode);
        logic [COUNT_BITS-1:0] cnt;
        mode_result_t          mode;
        if (int'(sample) < VALUE_COUNT)
        begin
            cnt = hist_mirror[sample];
            if (cnt != COUNT_MAX)
            begin
                cnt = cnt + 1'b1;
            end
            hist_mirror[sample] = cnt;
            if (cnt > lead_count || (cnt == lead_count && sample < lead_value))
            begin
                lead_count = cnt;
                lead_value = sample;
            end
        end
        if (last)
        begin
            mode.value = lead_value;
            mode.count = (64'(lead_count) > 64'hFFFF) ? 16'hFFFF : 16'(lead_count);
            pending_modes.push_back(typed ? typed_mode : mode);
            clear_mirror();
        end
    endfunction

    // offer one sample and wait for its transaction
    task automatic offer_sample(input logic [7:0] sample, input logic last,
                                input logic typed, input mode_result_t typed_mode);
        if (idle_on && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        tally_sample(sample, last, typed, typed_mode);
    endtask

    // random sets of mixed length, values over the full range or a narrow span
    task automatic send_random_sets(input int total);
        mode_result_t no_mode;
        int           sent;
        int           set_len;
        int           span_lo;
        bit           narrow;
        logic [7:0]   sample;
        no_mode = '0;
        sent    = 0;
        while (sent < total)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                set_len = $urandom_range(25, 80);
            end
            else
            begin
                set_len = $urandom_range(1, 24);
            end
            narrow  = ($urandom_range(0, 1) == 1);
            span_lo = $urandom_range(0, 248);
            for (int k = 0; k < set_len; k++)
            begin
                if (narrow)
                begin
                    sample = 8'($urandom_range(span_lo, span_lo + 7));
                end
                else
                begin
                    sample = 8'($urandom_range(0, 255));
                end
                offer_sample(sample, k == set_len - 1, 1'b0, no_mode);
                sent++;
            end
        end
    endtask

    // result side: random stalls and comparison against the oldest expected mode
    always @(posedge clk)
    begin
        mode_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_modes.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                    begin
                        $display("unexpected mode result: value %0d count %0d",
                                 m_tdata[7:0], m_tdata[23:8]);
                    end
                    fail_count++;
                end
                else
                begin
                    want = pending_modes.pop_front();
                    if (m_tdata[7:0] !== want.value || m_tdata[23:8] !== want.count)
                    begin
                        if (fail_count < REPORT_LIMIT)
                        begin
                            $display({"mode mismatch: expected value %0d count %0d, ",
                                      "got value %0d count %0d"},
                                     want.value, want.count, m_tdata[7:0], m_tdata[23:8]);
                        end
                        fail_count++;
                    end
                end
            end
            m_tready <= !(idle_on && $urandom_range(0, 99) < 10);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("histogram_mode_finder_unit_test NOT OK");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // stimulus
    initial
    begin
        mode_result_t typed_mode;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        idle_on  = 1'b1;
        clear_mirror();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            typed_mode.value = directed_rows[i].exp_value;
            typed_mode.count = directed_rows[i].exp_count;
            offer_sample(directed_rows[i].sample, directed_rows[i].last,
                         directed_rows[i].typed, typed_mode);
        end

        // random sets, first part
        send_random_sets(RANDOM_ITEMS / 3);

        // random sets with no idling on either side
        idle_on = 1'b0;
        send_random_sets(RANDOM_ITEMS / 3);
        idle_on = 1'b1;

        // random sets, last part
        send_random_sets(RANDOM_ITEMS / 3);
        s_tvalid <= 1'b0;

        // drain outstanding modes, then allow for the clearing sweep
        while (pending_modes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("histogram_mode_finder_unit_test OK");
        end
        else
        begin
            $display("histogram_mode_finder_unit_test NOT OK");
        end
        $finish;
    end

endmodule
